@@ src/mvm_pkg.sv @@
// Shared types, constants and arithmetic helpers for the matrix-vector multiplier.
`timescale 1ns / 1ps

package mvm_pkg;

  // Default largest matrix dimension.
  localparam int MAX_SIZE_DEF = 64;

  // Fixed field widths.
  localparam int CFG_W  = 7;
  localparam int ELEM_W = 32;
  localparam int ACC_W  = 64;
  localparam int ROW_W  = 6;

  // Reset value of the size register.
  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  // Address width of the queue between front and back.
  localparam int QUEUE_AW = 2;

  // Input item kinds.
  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_MATRIX = 1'b1
  } mode_t;

  // One matrix element with its vector operand and row bookkeeping.
  typedef struct packed {
    logic signed [ELEM_W-1:0] elem;
    logic signed [ELEM_W-1:0] vec;
    logic                     row_done;
    logic [ROW_W-1:0]         row_idx;
    logic                     last;
  } mvm_item_t;

  // Two's complement add that clamps to the most positive or negative value.
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] r;
    r = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (r[ACC_W-1] != a[ACC_W-1])) begin
      r = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ src/mvm_front.sv @@
// Front end: size register, vector store and row/column tracking of the matrix stream.
`timescale 1ns / 1ps

module mvm_front #(
  parameter int MAX_SIZE = mvm_pkg::MAX_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic signed [mvm_pkg::ELEM_W-1:0] in_element,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvm_pkg::CFG_W-1:0]         cfg_size_in_use,
  output logic                              push,
  output mvm_pkg::mvm_item_t                push_item,
  input  logic                              queue_full
);
  import mvm_pkg::*;

  localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int PW = IW + 1;

  logic [CFG_W-1:0]  size_r;
  logic [31:0]       eff_wide;
  logic [PW-1:0]     eff_size;

  logic [IW-1:0]     ld_r, ld_nxt, ld_pos;
  logic [IW-1:0]     col_r, col_nxt;
  logic [IW-1:0]     row_r, row_nxt;
  logic [PW-1:0]     col_p1, row_p1, ld_p1;
  logic [31:0]       row_wide;
  logic              row_done, last;
  logic              accept, acc_load, acc_matrix;

  logic                     stg_valid_r;
  logic signed [ELEM_W-1:0] stg_elem_r;
  logic signed [ELEM_W-1:0] stg_vec_r;
  logic                     stg_done_r;
  logic [ROW_W-1:0]         stg_row_r;
  logic                     stg_last_r;

  logic [ELEM_W-1:0] mem [MAX_SIZE];

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_size_in_use;
    end
  end

  // Effective size, clamped to 1..MAX_SIZE.
  always_comb begin
    if (size_r == '0) begin
      eff_wide = 32'd1;
    end else if (32'(size_r) > 32'(MAX_SIZE)) begin
      eff_wide = 32'(MAX_SIZE);
    end else begin
      eff_wide = 32'(size_r);
    end
    eff_size = eff_wide[PW-1:0];
  end

  // The stage register can take a new item unless it is stuck on a full queue.
  assign busy       = stg_valid_r && queue_full;
  assign accept     = start && !busy;
  assign acc_load   = accept && (mode_t'(in_mode) == MODE_LOAD);
  assign acc_matrix = accept && (mode_t'(in_mode) == MODE_MATRIX);

  // Load position, wrapped when it lies at or beyond the current size.
  always_comb begin
    ld_pos = ({1'b0, ld_r} >= eff_size) ? '0 : ld_r;
    ld_p1  = {1'b0, ld_pos} + PW'(1);
    ld_nxt = (ld_p1 >= eff_size) ? '0 : ld_p1[IW-1:0];
  end

  // Column and row stepping of the matrix stream.
  always_comb begin
    col_p1   = {1'b0, col_r} + PW'(1);
    row_p1   = {1'b0, row_r} + PW'(1);
    row_done = (col_p1 >= eff_size);
    last     = (row_p1 >= eff_size);
    col_nxt  = row_done ? '0 : col_p1[IW-1:0];
    row_nxt  = row_done ? (last ? '0 : row_p1[IW-1:0]) : row_r;
    row_wide = 32'(row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r  <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (acc_load) begin
        ld_r <= ld_nxt;
      end
      if (acc_matrix) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Vector store: written by loads, read for each matrix element.
  always_ff @(posedge clk) begin
    if (acc_load) begin
      mem[ld_pos] <= in_element;
    end
    if (acc_matrix) begin
      stg_vec_r <= mem[col_r];
    end
  end

  // Stage register that holds the item until the queue takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (acc_matrix) begin
      stg_valid_r <= 1'b1;
    end else if (push) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_matrix) begin
      stg_elem_r <= in_element;
      stg_done_r <= row_done;
      stg_row_r  <= row_wide[ROW_W-1:0];
      stg_last_r <= last;
    end
  end

  assign push               = stg_valid_r && !queue_full;
  assign push_item.elem     = stg_elem_r;
  assign push_item.vec      = stg_vec_r;
  assign push_item.row_done = stg_done_r;
  assign push_item.row_idx  = stg_row_r;
  assign push_item.last     = stg_last_r;

endmodule

@@ src/mvm_queue.sv @@
// Short queue that decouples the front end from the multiply-accumulate back end.
`timescale 1ns / 1ps

module mvm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mvm_pkg::mvm_item_t push_item,
  output logic               full,
  output logic               pop,
  output mvm_pkg::mvm_item_t pop_item
);
  import mvm_pkg::*;

  localparam int DEPTH = 1 << QUEUE_AW;

  mvm_item_t           slots_r [DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  // The back end drains one entry every cycle the queue is not empty.
  assign full     = (count_r == (QUEUE_AW + 1)'(DEPTH));
  assign pop      = (count_r != '0);
  assign pop_item = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QUEUE_AW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ src/mvm_back.sv @@
// Back end: registered multiply, saturating accumulate and row result output.
`timescale 1ns / 1ps

module mvm_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop,
  input  mvm_pkg::mvm_item_t                pop_item,
  output logic                              out_strobe,
  output logic signed [mvm_pkg::ACC_W-1:0]  out_dot_product,
  output logic [mvm_pkg::ROW_W-1:0]         out_row_index,
  output logic                              out_last_row
);
  import mvm_pkg::*;

  logic                    mul_valid_r;
  logic signed [ACC_W-1:0] prod_r;
  logic                    mul_done_r;
  logic [ROW_W-1:0]        mul_row_r;
  logic                    mul_last_r;

  logic [ACC_W-1:0]        acc_r, acc_sum;
  logic                    strobe_r;
  logic [ACC_W-1:0]        dot_r;
  logic [ROW_W-1:0]        row_r;
  logic                    last_r;

  // Multiply stage: exact Q32.32 product of two Q16.16 values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prod_r     <= pop_item.elem * pop_item.vec;
      mul_done_r <= pop_item.row_done;
      mul_row_r  <= pop_item.row_idx;
      mul_last_r <= pop_item.last;
    end
  end

  // Accumulate stage: the sum restarts after each finished row.
  assign acc_sum = sat_add(acc_r, prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= mul_valid_r && mul_done_r;
      if (mul_valid_r) begin
        acc_r <= mul_done_r ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid_r && mul_done_r) begin
      dot_r  <= acc_sum;
      row_r  <= mul_row_r;
      last_r <= mul_last_r;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_dot_product = dot_r;
  assign out_row_index   = row_r;
  assign out_last_row    = last_r;

endmodule

@@ src/matrix_vector_multiply.sv @@
// Top level of the fixed-point dense matrix-vector multiplier.
`timescale 1ns / 1ps
// Usage:
//   Items enter on in_mode / in_element and transfer at a clock edge with start high
//   and busy low. Mode load writes the next vector element; mode matrix supplies the
//   next matrix element in row-major order.
//   cfg_size_in_use sets the matrix dimension (clamped to 1..MAX_SIZE); cfg_ready is
//   always high, and a write transfers when cfg_valid is high. Write it only while idle.
//   At the end of each row the Q32.32 saturated dot product appears on out_dot_product
//   with out_row_index and out_last_row, flagged by out_strobe high for one cycle.
// Timing:
//   One item is taken per cycle while busy is low. A row result appears once the row's final
//   element has passed the vector store read into the stage register, the queue
//   slot, the multiplier register, then the accumulator feeding the output register.
//   The rate is set by the single 32x32 multiplier and the one-read vector store, each
//   used once per matrix element.
// Reset:
//   rst_n clears the size register to 64, the load, row and column positions, the queue
//   and the running sum. Vector store contents are undefined until loaded.
//   The receiver cannot stall: out_strobe flags each result for exactly one cycle.

module matrix_vector_multiply #(
  parameter int MAX_SIZE = mvm_pkg::MAX_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic signed [mvm_pkg::ELEM_W-1:0] in_element,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvm_pkg::CFG_W-1:0]         cfg_size_in_use,
  output logic                              out_strobe,
  output logic signed [mvm_pkg::ACC_W-1:0]  out_dot_product,
  output logic [mvm_pkg::ROW_W-1:0]         out_row_index,
  output logic                              out_last_row
);
  import mvm_pkg::*;

  logic      push, queue_full, pop;
  mvm_item_t push_item, pop_item;

  // Front end: classify items, keep the vector and the stream position.
  mvm_front #(
    .MAX_SIZE(MAX_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_element     (in_element),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_size_in_use(cfg_size_in_use),
    .push           (push),
    .push_item      (push_item),
    .queue_full     (queue_full)
  );

  // Queue between the two halves.
  mvm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (queue_full),
    .pop      (pop),
    .pop_item (pop_item)
  );

  // Back end: multiply-accumulate and result output.
  mvm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop            (pop),
    .pop_item       (pop_item),
    .out_strobe     (out_strobe),
    .out_dot_product(out_dot_product),
    .out_row_index  (out_row_index),
    .out_last_row   (out_last_row)
  );

endmodule
